FILE: sv/http_request_line_parser_assert.svh
// assertion macros for the request line parser
// used by the top level, which provides clock and reset in scope
`ifndef HTTP_REQUEST_LINE_PARSER_ASSERT_SVH
`define HTTP_REQUEST_LINE_PARSER_ASSERT_SVH

// same-cycle implication
`define HRLP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hrlp: same-cycle check failed");

// next-cycle implication
`define HRLP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hrlp: next-cycle check failed");

`endif

FILE: sv/hrlp_pkg.sv
// types, codes and match tables for the request line parser
// no dependencies
`default_nettype none

package hrlp_pkg;

   localparam int unsigned CountWidth = 8;
   localparam int unsigned CsrIndexWidth = 1;

   localparam logic [CsrIndexWidth-1:0] CSR_METHOD_LIMIT  = 1'b0;
   localparam logic [CsrIndexWidth-1:0] CSR_VERSION_LIMIT = 1'b1;

   localparam logic [7:0] METHOD_LIMIT_RESET  = 8'd16;
   localparam logic [7:0] VERSION_LIMIT_RESET = 8'd16;

   localparam logic [1:0] SEC_METHOD  = 2'd0;
   localparam logic [1:0] SEC_PATH    = 2'd1;
   localparam logic [1:0] SEC_QUERY   = 2'd2;
   localparam logic [1:0] SEC_VERSION = 2'd3;

   localparam logic [2:0] CLS_METHOD   = 3'd0;
   localparam logic [2:0] CLS_SPACE    = 3'd1;
   localparam logic [2:0] CLS_PATH     = 3'd2;
   localparam logic [2:0] CLS_QUESTION = 3'd3;
   localparam logic [2:0] CLS_QUERY    = 3'd4;
   localparam logic [2:0] CLS_VERSION  = 3'd5;

   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_NO_SPACE1    = 3'd1;
   localparam logic [2:0] ST_NO_SPACE2    = 3'd2;
   localparam logic [2:0] ST_METHOD_LEN   = 3'd3;
   localparam logic [2:0] ST_EMPTY_TARGET = 3'd4;
   localparam logic [2:0] ST_EMPTY_PATH   = 3'd5;
   localparam logic [2:0] ST_VERSION_LEN  = 3'd6;

   localparam logic [2:0] GET_DONE = 3'd3;
   localparam logic [2:0] GET_FAIL = 3'd4;
   localparam logic [3:0] VER_DONE = 4'd8;
   localparam logic [3:0] VER_FAIL = 4'd9;

   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_QUESTION = 8'h3F;

   typedef struct packed {
      logic [7:0] line_byte;
      logic       line_end;
   } hrlp_req_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic [2:0] byte_class;
      logic       line_done;
      logic [2:0] status;
      logic       is_get;
      logic       is_http11;
   } hrlp_rsp_type;

   typedef struct packed {
      logic [1:0]            section;
      logic [CountWidth-1:0] method_count;
      logic [CountWidth-1:0] target_count;
      logic                  empty_path_seen;
      logic [CountWidth-1:0] version_count;
      logic [2:0]            get_match;
      logic [3:0]            version_match;
   } hrlp_state_type;

   localparam hrlp_state_type STATE_CLEAR = '{
      section: SEC_METHOD, method_count: '0, target_count: '0,
      empty_path_seen: 1'b0, version_count: '0, get_match: '0, version_match: '0};

   function automatic logic [7:0] get_char(input logic [1:0] idx);
      logic [7:0] c;
      case (idx)
         2'd0:    c = 8'h47; // G
         2'd1:    c = 8'h45; // E
         default: c = 8'h54; // T
      endcase
      return c;
   endfunction

   function automatic logic [7:0] ver_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h48; // H
         3'd1:    c = 8'h54; // T
         3'd2:    c = 8'h54; // T
         3'd3:    c = 8'h50; // P
         3'd4:    c = 8'h2F; // /
         3'd5:    c = 8'h31; // 1
         3'd6:    c = 8'h2E; // .
         default: c = 8'h31; // 1
      endcase
      return c;
   endfunction

   function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

endpackage

`default_nettype wire

FILE: sv/hrlp_step.sv
// per-byte classification, state update and end-of-line status
// depends on hrlp_pkg
`default_nettype none

module hrlp_step (
   input  hrlp_pkg::hrlp_state_type state,
   input  hrlp_pkg::hrlp_req_type   req,
   input  logic [7:0]               method_limit,
   input  logic [7:0]               version_limit,
   output hrlp_pkg::hrlp_state_type state_next,
   output hrlp_pkg::hrlp_rsp_type   rsp
);
   import hrlp_pkg::*;

   hrlp_state_type upd;
   logic [2:0]     cls;
   logic [7:0]     b;

   assign b = req.line_byte;

   always_comb begin
      upd = state;
      cls = CLS_METHOD;
      unique case (state.section)
         SEC_METHOD: begin
            if (b == CHAR_SPACE) begin
               cls = CLS_SPACE;
               upd.section = SEC_PATH;
            end else begin
               cls = CLS_METHOD;
               upd.method_count = sat_inc(state.method_count);
               if (state.get_match < GET_DONE && b == get_char(state.get_match[1:0]))
                  upd.get_match = state.get_match + 3'd1;
               else
                  upd.get_match = GET_FAIL;
            end
         end
         SEC_PATH: begin
            if (b == CHAR_SPACE) begin
               cls = CLS_SPACE;
               upd.section = SEC_VERSION;
            end else if (b == CHAR_QUESTION) begin
               cls = CLS_QUESTION;
               if (state.target_count == '0)
                  upd.empty_path_seen = 1'b1;
               upd.target_count = sat_inc(state.target_count);
               upd.section = SEC_QUERY;
            end else begin
               cls = CLS_PATH;
               upd.target_count = sat_inc(state.target_count);
            end
         end
         SEC_QUERY: begin
            if (b == CHAR_SPACE) begin
               cls = CLS_SPACE;
               upd.section = SEC_VERSION;
            end else begin
               cls = CLS_QUERY;
               upd.target_count = sat_inc(state.target_count);
            end
         end
         default: begin
            cls = CLS_VERSION;
            upd.version_count = sat_inc(state.version_count);
            if (state.version_match < VER_DONE && b == ver_char(state.version_match[2:0]))
               upd.version_match = state.version_match + 4'd1;
            else
               upd.version_match = VER_FAIL;
         end
      endcase
   end

   always_comb begin
      rsp = '0;
      rsp.data_byte  = b;
      rsp.byte_class = cls;
      rsp.line_done  = req.line_end;
      if (req.line_end) begin
         // priority order: lowest code that applies wins
         if (upd.section == SEC_METHOD)
            rsp.status = ST_NO_SPACE1;
         else if (upd.section != SEC_VERSION)
            rsp.status = ST_NO_SPACE2;
         else if (upd.method_count == '0 || upd.method_count >= method_limit)
            rsp.status = ST_METHOD_LEN;
         else if (upd.target_count == '0)
            rsp.status = ST_EMPTY_TARGET;
         else if (upd.empty_path_seen)
            rsp.status = ST_EMPTY_PATH;
         else if (upd.version_count == '0 || upd.version_count >= version_limit)
            rsp.status = ST_VERSION_LEN;
         else
            rsp.status = ST_OK;
         rsp.is_get    = (upd.get_match == GET_DONE);
         rsp.is_http11 = (upd.version_match == VER_DONE);
      end
   end

   assign state_next = req.line_end ? STATE_CLEAR : upd;

endmodule

`default_nettype wire

FILE: sv/http_request_line_parser.sv
// Streaming HTTP request line parser, one byte per transaction.
// req channel: one byte of the request line plus a flag on its final byte.
// rsp channel: the byte passed through with its class (method, separator
//   space, path, question mark, query, version); on the final byte also the
//   status and the GET / HTTP/1.1 match flags, which read zero elsewhere.
// csr port: write-only, index 0 method_limit, index 1 version_limit, taken
//   on any cycle with csr_write high; change them only between lines.
// Result: registered; it appears in the cycle after the byte is accepted.
// Throughput: one byte per cycle while the receiver takes results; the
//   per-byte state update and the end-of-line status are combinational.
// Stall: req_ready follows rsp_ready while a result is held, so the block
//   keeps taking bytes while the receiver takes results; a held result
//   stays unchanged until taken.
// Reset: clears the parse state and the result valid, and sets both
//   limits to 16. The line state also clears after every final byte.
// Depends on hrlp_pkg, hrlp_step and http_request_line_parser_assert.svh.
`default_nettype none

module http_request_line_parser (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  hrlp_pkg::hrlp_req_type                 req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output hrlp_pkg::hrlp_rsp_type                 rsp_data,
   input  logic                                   csr_write,
   input  logic [hrlp_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [7:0]                             csr_data
);
   import hrlp_pkg::*;

   hrlp_state_type state_ff, state_in;
   hrlp_rsp_type   rsp_ff, rsp_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     method_limit_ff, version_limit_ff;
   logic           req_accept;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   hrlp_step u_step (
      .state         (state_ff),
      .req           (req_data),
      .method_limit  (method_limit_ff),
      .version_limit (version_limit_ff),
      .state_next    (state_in),
      .rsp           (rsp_in)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept)
            state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept)
         rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         method_limit_ff  <= METHOD_LIMIT_RESET;
         version_limit_ff <= VERSION_LIMIT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_METHOD_LIMIT:  method_limit_ff  <= csr_data;
            CSR_VERSION_LIMIT: version_limit_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`include "http_request_line_parser_assert.svh"

   // line state is back to the start after a final byte
   `HRLP_ASSERT_NEXT(a_clear_after_end, req_accept && req_data.line_end, state_ff == STATE_CLEAR)
   // status and match flags only on the final byte
   `HRLP_ASSERT_NOW(a_status_only_at_end, rsp_valid_ff && !rsp_ff.line_done, rsp_ff.status == ST_OK && !rsp_ff.is_get && !rsp_ff.is_http11)
   // match trackers never pass their fail codes
   `HRLP_ASSERT_NOW(a_match_range, 1'b1, state_ff.get_match <= GET_FAIL && state_ff.version_match <= VER_FAIL)
   // version bytes only come once the second space has been seen
   `HRLP_ASSERT_NOW(a_version_class, req_accept && state_ff.section != SEC_VERSION, rsp_in.byte_class != CLS_VERSION)

endmodule

`default_nettype wire
